>>> hdl/taylor_sine_cosine_unit_assert.svh
// Assertion macros for the Taylor sine/cosine unit.
// Used by the files under hdl that check their own logic; needs clk and rst in scope.
`ifndef TAYLOR_SINE_COSINE_UNIT_ASSERT_SVH
`define TAYLOR_SINE_COSINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TSC_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tsc assertion failed");
`define TSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tsc assertion failed");
`else
`define TSC_ASSERT_NOW(label, cond)
`define TSC_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> hdl/tsc_pkg.sv
// Shared constants, payload structs and the pipeline lane type of the
// Taylor sine/cosine unit. No dependencies.
package tsc_pkg;

  localparam int FRACTION_BITS  = 29;
  localparam int GUARD_BITS     = 8;
  localparam int INNER_BITS     = FRACTION_BITS + GUARD_BITS;
  localparam int ANGLE_W        = 32;
  localparam int VALUE_W        = 31;
  localparam int MAG_W          = 31;                 // |angle| after clamping to pi
  localparam int X_W            = MAG_W + GUARD_BITS; // |x| in the inner format
  localparam int X2_W           = 41;                 // x^2 < 10 in the inner format
  localparam int T_W            = 40;                 // every term stays below 8
  localparam int N_W            = 44;                 // rounded product plus d/2
  localparam int ACC_W          = 44;
  localparam int D_W            = 11;
  localparam int RECIP_SHIFT    = N_W;
  localparam int TERM_COUNT_DEF = 10;

  localparam logic CMD_SINE   = 1'b0;
  localparam logic CMD_COSINE = 1'b1;

  // pi in Q2.29 and one in Q1.29
  localparam logic signed [ANGLE_W-1:0] PI_F  = 32'sd1686629713;
  localparam logic signed [VALUE_W-1:0] ONE_F = 31'sd536870912;

  typedef struct packed {
    logic                      cmd;
    logic signed [ANGLE_W-1:0] angle;
  } tsc_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      clamped;
  } tsc_out_t;

  typedef struct packed {
    logic                    valid;
    logic                    cosine;
    logic                    neg;
    logic                    clamped;
    logic [X2_W-1:0]         x2;
    logic [T_W-1:0]          t;
    logic signed [ACC_W-1:0] acc;
  } tsc_lane_t;

endpackage

>>> hdl/taylor_sine_cosine_unit.sv
// Taylor sine/cosine unit: angle in signed Q2.29, result in signed Q1.29. One
// transfer is accepted per cycle while the skid register is empty. The pipeline has
// four front stages for the clamp and x^2, seven per series term for its split
// 40 x 41 bit product, the reciprocal divide by the term's constant and the
// accumulate, and two for rounding and saturation. A one-entry skid register at the
// output lets the pipeline take one more transfer while a result waits.
// Depends on tsc_pkg, tsc_front, tsc_term, tsc_back and the assertion header.
`include "taylor_sine_cosine_unit_assert.svh"

module taylor_sine_cosine_unit #(
  parameter int TERM_COUNT = tsc_pkg::TERM_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              arg_valid,
  output logic              arg_ready,
  input  tsc_pkg::tsc_in_t  arg,
  output logic              res_valid,
  input  logic              res_ready,
  output tsc_pkg::tsc_out_t res
);

  logic              en;
  logic              skid_full;
  tsc_pkg::tsc_out_t skid;
  logic              pipe_valid;
  tsc_pkg::tsc_out_t pipe_res;

  tsc_pkg::tsc_lane_t chain [TERM_COUNT];

  assign en        = !skid_full;
  assign arg_ready = en;
  assign res_valid = skid_full || pipe_valid;
  assign res       = skid_full ? skid : pipe_res;

  tsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .arg_valid (arg_valid),
    .arg       (arg),
    .lane      (chain[0])
  );

  for (genvar k = 1; k < TERM_COUNT; k++) begin : g_term
    tsc_term #(
      .K (k)
    ) u_term (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (chain[k-1]),
      .lane_out (chain[k])
    );
  end

  tsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .lane      (chain[TERM_COUNT-1]),
    .out_valid (pipe_valid),
    .out_data  (pipe_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (res_ready) begin
        skid_full <= 1'b0;
      end
    end else if (pipe_valid && !res_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && pipe_valid && !res_ready) begin
      skid <= pipe_res;
    end
  end

  `TSC_ASSERT_NOW(res_range_a, !res_valid || (res.value <= tsc_pkg::ONE_F && res.value >= -tsc_pkg::ONE_F))
  `TSC_ASSERT_NEXT(skid_load_a, !skid_full && pipe_valid && !res_ready, skid_full && skid == $past(pipe_res))

endmodule

>>> hdl/tsc_front.sv
// Front of the pipeline: clamp, magnitude, and x^2 in the inner format.
// Depends on tsc_pkg and the assertion header.
`include "taylor_sine_cosine_unit_assert.svh"

module tsc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               arg_valid,
  input  tsc_pkg::tsc_in_t   arg,
  output tsc_pkg::tsc_lane_t lane
);

  localparam int XL   = tsc_pkg::X_W - tsc_pkg::X_W / 2;
  localparam int XH   = tsc_pkg::X_W / 2;
  localparam int LL_W = 2 * XL;
  localparam int LH_W = XL + XH;
  localparam int HH_W = 2 * XH;
  localparam int SQ_W = 2 * tsc_pkg::X_W;

  logic                               over_hi;
  logic                               over_lo;
  logic                               neg;
  logic signed [tsc_pkg::ANGLE_W-1:0] ang_c;
  logic        [tsc_pkg::ANGLE_W-1:0] mag;
  logic        [tsc_pkg::X_W-1:0]     ax;
  logic        [XL-1:0]               ax_lo;
  logic        [XH-1:0]               ax_hi;
  logic        [SQ_W:0]               rnd;

  tsc_pkg::tsc_lane_t s1_next, s1, s2, s3, lane_next;

  logic [LL_W-1:0] pp_ll;
  logic [LH_W-1:0] pp_lh;
  logic [HH_W-1:0] pp_hh;
  logic [SQ_W-1:0] sq;

  always_comb begin
    over_hi = arg.angle > tsc_pkg::PI_F;
    over_lo = arg.angle < -tsc_pkg::PI_F;
    if (over_hi) begin
      ang_c = tsc_pkg::PI_F;
    end else if (over_lo) begin
      ang_c = -tsc_pkg::PI_F;
    end else begin
      ang_c = arg.angle;
    end
    neg = ang_c[tsc_pkg::ANGLE_W-1];
    mag = neg ? tsc_pkg::ANGLE_W'(-ang_c) : tsc_pkg::ANGLE_W'(ang_c);

    s1_next         = '0;
    s1_next.valid   = arg_valid;
    s1_next.cosine  = arg.cmd == tsc_pkg::CMD_COSINE;
    s1_next.neg     = neg;
    s1_next.clamped = over_hi | over_lo;
    s1_next.t       = tsc_pkg::T_W'({mag[tsc_pkg::MAG_W-1:0], {tsc_pkg::GUARD_BITS{1'b0}}});
  end

  assign ax    = s1.t[tsc_pkg::X_W-1:0];
  assign ax_lo = ax[XL-1:0];
  assign ax_hi = ax[tsc_pkg::X_W-1:XL];

  always_comb begin
    rnd = (SQ_W + 1)'(sq) + ((SQ_W + 1)'(1) << (tsc_pkg::INNER_BITS - 1));
    lane_next     = s3;
    lane_next.x2  = tsc_pkg::X2_W'(rnd >> tsc_pkg::INNER_BITS);
    lane_next.t   = s3.cosine ? (tsc_pkg::T_W'(1) << tsc_pkg::INNER_BITS) : s3.t;
    lane_next.acc = $signed(tsc_pkg::ACC_W'(lane_next.t));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid   <= 1'b0;
      s2.valid   <= 1'b0;
      s3.valid   <= 1'b0;
      lane.valid <= 1'b0;
    end else if (en) begin
      s1   <= s1_next;
      s2   <= s1;
      s3   <= s2;
      lane <= lane_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= LL_W'(ax_lo) * LL_W'(ax_lo);
      pp_lh <= LH_W'(ax_lo) * LH_W'(ax_hi);
      pp_hh <= HH_W'(ax_hi) * HH_W'(ax_hi);
      sq    <= SQ_W'(pp_ll) + (SQ_W'(pp_lh) << (XL + 1)) + (SQ_W'(pp_hh) << (2 * XL));
    end
  end

  `TSC_ASSERT_NEXT(front_load_a, arg_valid && en, s1.valid)
  `TSC_ASSERT_NEXT(front_hold_a, !en, $stable(lane) && $stable(s1.valid))

endmodule

>>> hdl/tsc_term.sv
// One Taylor term: t_k = round(round(t_{k-1} * x^2) / d_k), added to the sum
// with alternating sign. Seven register stages. Depends on tsc_pkg.
module tsc_term #(
  parameter int K = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tsc_pkg::tsc_lane_t lane_in,
  output tsc_pkg::tsc_lane_t lane_out
);

  localparam int D_SIN = (2 * K) * (2 * K + 1);
  localparam int D_COS = (2 * K - 1) * (2 * K);
  localparam logic [tsc_pkg::N_W-1:0] M_SIN =
    tsc_pkg::N_W'((64'd1 << tsc_pkg::RECIP_SHIFT) / D_SIN);
  localparam logic [tsc_pkg::N_W-1:0] M_COS =
    tsc_pkg::N_W'((64'd1 << tsc_pkg::RECIP_SHIFT) / D_COS);
  localparam logic SUBTRACT = (K % 2) == 1;

  localparam int TL    = tsc_pkg::T_W / 2;
  localparam int TH    = tsc_pkg::T_W - TL;
  localparam int XL    = tsc_pkg::X2_W / 2;
  localparam int XH    = tsc_pkg::X2_W - XL;
  localparam int PP1_W = TH + XH;
  localparam int P_W   = tsc_pkg::T_W + tsc_pkg::X2_W;
  localparam int NL    = tsc_pkg::N_W / 2;
  localparam int NH    = tsc_pkg::N_W - NL;
  localparam int PP2_W = 2 * NH;
  localparam int Q_W   = 2 * tsc_pkg::N_W;

  tsc_pkg::tsc_lane_t s1, s2, s3, s4, s5, s6, lane_next;

  logic [PP1_W-1:0]        p1_ll, p1_lh, p1_hl, p1_hh;
  logic [P_W-1:0]          prod;
  logic [P_W:0]            rp;
  logic [tsc_pkg::N_W-1:0] n3, n4, n5, n6;
  logic [PP2_W-1:0]        p4_ll, p4_lh, p4_hl, p4_hh;
  logic [tsc_pkg::N_W-1:0] q5, q6, qd6;
  logic signed [tsc_pkg::ACC_W-1:0] accp6;

  logic [tsc_pkg::D_W-1:0] d3, d5, d6;
  logic [tsc_pkg::N_W-1:0] m3;
  logic [tsc_pkg::N_W-1:0] r6;
  logic                    inc6;
  logic [tsc_pkg::N_W-1:0] n3_next;

  assign d3   = s2.cosine ? tsc_pkg::D_W'(D_COS) : tsc_pkg::D_W'(D_SIN);
  assign m3   = s3.cosine ? M_COS : M_SIN;
  assign d5   = s5.cosine ? tsc_pkg::D_W'(D_COS) : tsc_pkg::D_W'(D_SIN);
  assign d6   = s6.cosine ? tsc_pkg::D_W'(D_COS) : tsc_pkg::D_W'(D_SIN);

  // round the product to the inner format and add d/2 ahead of the division
  always_comb begin
    rp      = (P_W + 1)'(prod) + ((P_W + 1)'(1) << (tsc_pkg::INNER_BITS - 1));
    n3_next = tsc_pkg::N_W'(rp >> tsc_pkg::INNER_BITS) + tsc_pkg::N_W'(d3 >> 1);
  end

  // the reciprocal quotient is low by at most one
  always_comb begin
    r6            = n6 - qd6;
    inc6          = r6 >= tsc_pkg::N_W'(d6);
    lane_next     = s6;
    lane_next.t   = tsc_pkg::T_W'(q6 + tsc_pkg::N_W'(inc6));
    lane_next.acc = SUBTRACT ? accp6 - $signed(tsc_pkg::ACC_W'(inc6))
                             : accp6 + $signed(tsc_pkg::ACC_W'(inc6));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid       <= 1'b0;
      s2.valid       <= 1'b0;
      s3.valid       <= 1'b0;
      s4.valid       <= 1'b0;
      s5.valid       <= 1'b0;
      s6.valid       <= 1'b0;
      lane_out.valid <= 1'b0;
    end else if (en) begin
      s1       <= lane_in;
      s2       <= s1;
      s3       <= s2;
      s4       <= s3;
      s5       <= s4;
      s6       <= s5;
      lane_out <= lane_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ll <= PP1_W'(lane_in.t[TL-1:0]) * PP1_W'(lane_in.x2[XL-1:0]);
      p1_lh <= PP1_W'(lane_in.t[TL-1:0]) * PP1_W'(lane_in.x2[tsc_pkg::X2_W-1:XL]);
      p1_hl <= PP1_W'(lane_in.t[tsc_pkg::T_W-1:TL]) * PP1_W'(lane_in.x2[XL-1:0]);
      p1_hh <= PP1_W'(lane_in.t[tsc_pkg::T_W-1:TL])
             * PP1_W'(lane_in.x2[tsc_pkg::X2_W-1:XL]);

      prod <= P_W'(p1_ll) + (P_W'(p1_lh) << XL) + (P_W'(p1_hl) << TL)
            + (P_W'(p1_hh) << (TL + XL));

      n3 <= n3_next;

      p4_ll <= PP2_W'(n3[NL-1:0]) * PP2_W'(m3[NL-1:0]);
      p4_lh <= PP2_W'(n3[NL-1:0]) * PP2_W'(m3[tsc_pkg::N_W-1:NL]);
      p4_hl <= PP2_W'(n3[tsc_pkg::N_W-1:NL]) * PP2_W'(m3[NL-1:0]);
      p4_hh <= PP2_W'(n3[tsc_pkg::N_W-1:NL]) * PP2_W'(m3[tsc_pkg::N_W-1:NL]);
      n4    <= n3;

      q5 <= tsc_pkg::N_W'((Q_W'(p4_ll) + (Q_W'(p4_lh) << NL) + (Q_W'(p4_hl) << NL)
            + (Q_W'(p4_hh) << (2 * NL))) >> tsc_pkg::RECIP_SHIFT);
      n5 <= n4;

      qd6   <= q5 * tsc_pkg::N_W'(d5);
      q6    <= q5;
      n6    <= n5;
      accp6 <= SUBTRACT ? s5.acc - $signed(q5) : s5.acc + $signed(q5);
    end
  end

endmodule

>>> hdl/tsc_back.sv
// Back of the pipeline: drops the guard bits with rounding, saturates to
// plus or minus one and restores the sine's sign. Depends on tsc_pkg.
module tsc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tsc_pkg::tsc_lane_t lane,
  output logic               out_valid,
  output tsc_pkg::tsc_out_t  out_data
);

  localparam int R_W = tsc_pkg::ACC_W - tsc_pkg::GUARD_BITS;
  localparam logic signed [R_W-1:0] ONE_R = R_W'(tsc_pkg::ONE_F);

  logic                    b1_valid;
  logic                    b1_flip;
  logic                    b1_clamped;
  logic signed [R_W-1:0]   b1_q;
  logic signed [R_W-1:0]   q_next;
  logic signed [tsc_pkg::ACC_W-1:0] v;
  logic signed [R_W-1:0]   sat;
  tsc_pkg::tsc_out_t       out_next;

  // floor of (acc + half) / 2^GUARD covers both signs
  always_comb begin
    v      = lane.acc + $signed(tsc_pkg::ACC_W'(1) << (tsc_pkg::GUARD_BITS - 1));
    q_next = R_W'(v >>> tsc_pkg::GUARD_BITS);
  end

  always_comb begin
    if (b1_q > ONE_R) begin
      sat = ONE_R;
    end else if (b1_q < -ONE_R) begin
      sat = -ONE_R;
    end else begin
      sat = b1_q;
    end
    out_next.value   = tsc_pkg::VALUE_W'(b1_flip ? -sat : sat);
    out_next.clamped = b1_clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= lane.valid;
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_q       <= q_next;
      b1_flip    <= !lane.cosine && lane.neg;
      b1_clamped <= lane.clamped;
      out_data   <= out_next;
    end
  end

endmodule

>>> tb/sv/sincos_checker.sv
// Checker for the Taylor sine/cosine unit: watches both channels, predicts each result
// in fixed point and compares it with what comes out. Depends on tsc_pkg.
module sincos_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              arg_valid,
  input  logic              arg_ready,
  input  tsc_pkg::tsc_in_t  arg,
  input  logic              res_valid,
  input  logic              res_ready,
  input  tsc_pkg::tsc_out_t res,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsc_pkg::*;

  tsc_out_t sincos_due[$];

  // round(a * b / 2^s), halves up
  function automatic logic [63:0] mul_round_shift(input logic [63:0] a, input logic [63:0] b,
                                                  input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = (p + (128'd1 << (s - 1))) >> s;
    return p[63:0];
  endfunction

  function automatic tsc_out_t taylor_sincos(input tsc_in_t item);
    logic signed [63:0] ang;
    logic signed [63:0] acc;
    logic signed [63:0] q;
    logic signed [63:0] unity;
    logic [63:0]        ax;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        div;
    logic               neg;
    logic               cosine;
    int                 k;
    tsc_out_t           r;
    cosine = (item.cmd == CMD_COSINE);
    unity = 64'sd1 <<< FRACTION_BITS;
    ang = item.angle;
    r.clamped = 1'b0;
    if (ang > PI_F) begin
      ang = PI_F;
      r.clamped = 1'b1;
    end else if (ang < -PI_F) begin
      ang = -PI_F;
      r.clamped = 1'b1;
    end
    neg = ang < 0;
    ax = 64'(neg ? -ang : ang) << GUARD_BITS;
    x2 = mul_round_shift(ax, ax, INNER_BITS);
    term = cosine ? (64'd1 << INNER_BITS) : ax;
    acc = $signed(term);
    for (k = 1; k < TERM_COUNT_DEF; k++) begin
      div = cosine ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
      term = mul_round_shift(term, x2, INNER_BITS);
      term = (term + div / 2) / div;
      if (k % 2 == 1)
        acc = acc - $signed(term);
      else
        acc = acc + $signed(term);
    end
    // drop guard bits, halves toward +inf
    q = (acc + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    if (q > unity)
      q = unity;
    if (q < -unity)
      q = -unity;
    if (!cosine && neg)
      q = -q;
    r.value = q[VALUE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    tsc_out_t want;
    logic     bad;
    if (rst) begin
      sincos_due.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (sincos_due.size() == 0) begin
          $display("%0t: result transfer with nothing due: value %0d clamped %0b",
                   $time, res.value, res.clamped);
          errors <= errors + 1;
        end else begin
          want = sincos_due.pop_front();
          bad  = 1'b0;
          if (res.value !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, want.value, res.value);
            bad = 1'b1;
          end
          if (res.clamped !== want.clamped) begin
            $display("%0t: clamped mismatch: expected %0b, actual %0b",
                     $time, want.clamped, res.clamped);
            bad = 1'b1;
          end
          if (bad)
            errors <= errors + 1;
        end
      end
      if (arg_valid && arg_ready)
        sincos_due.push_back(taylor_sincos(arg));
      pending <= sincos_due.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the Taylor sine/cosine unit test: clock, reset, angle stimulus, result sink and
// watchdog. Depends on tsc_pkg, taylor_sine_cosine_unit and sincos_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tsc_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 120;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     arg_valid = 1'b0;
  logic     arg_ready;
  tsc_in_t  arg       = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  tsc_out_t res;

  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   rx_hold     = 0;
  logic rx_fast     = 1'b0;
  logic tx_fast     = 1'b0;

  always #5 clk = ~clk;

  taylor_sine_cosine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .arg_valid (arg_valid),
    .arg_ready (arg_ready),
    .arg       (arg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  sincos_checker sincos_watch (
    .clk       (clk),
    .rst       (rst),
    .arg_valid (arg_valid),
    .arg_ready (arg_ready),
    .arg       (arg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .errors    (errors),
    .pending   (pending)
  );

  // result side: random stall after each transfer, with occasional no-stall stretches
  always @(posedge clk) begin : result_sink
    int n;
    if (rst) begin
      res_ready <= 1'b0;
      rx_hold   <= 0;
      rx_fast   <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      res_ready <= (rx_hold == 1);
    end else if (res_valid && res_ready) begin
      if ($urandom_range(0, 63) == 0)
        rx_fast <= ~rx_fast;
      n = rx_fast ? 0 : $urandom_range(0, 15);
      res_ready <= (n == 0);
      rx_hold   <= n;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (arg_valid && arg_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_arg(input logic cmd, input logic signed [ANGLE_W-1:0] angle);
    int gap;
    tsc_in_t item;
    gap = tx_fast ? 0 : $urandom_range(0, 15);
    item.cmd   = cmd;
    item.angle = angle;
    if (gap > 0) begin
      arg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    arg_valid <= 1'b1;
    arg       <= item;
    do @(posedge clk); while (!arg_ready);
  endtask

  initial begin : stimulus
    logic signed [ANGLE_W-1:0] corner_angles [12] = '{
      32'sd0, 32'sd1, -32'sd1, PI_F, -PI_F, PI_F + 32'sd1, -PI_F - 32'sd1,
      32'sh7FFFFFFF, 32'sh80000000, 32'sd843314857, -32'sd843314857, 32'sd536870912
    };
    logic signed [ANGLE_W-1:0] a;
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // corners: zero, +-pi and just beyond, full-scale codes, near pi/2, one radian
    foreach (corner_angles[i]) begin
      send_arg(CMD_SINE, corner_angles[i]);
      send_arg(CMD_COSINE, corner_angles[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0)
        tx_fast = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        a = $urandom_range(0, 32'd3373259426) - PI_F;
      end else if (pick == 7) begin
        a = PI_F + $signed($urandom_range(0, 8)) - 32'sd4;
        if ($urandom_range(0, 1) == 1)
          a = -a;
      end else if (pick == 8) begin
        a = $urandom_range(0, 4095);
        if ($urandom_range(0, 1) == 1)
          a = -a;
      end else begin
        a = $urandom();
      end
      send_arg($urandom_range(0, 1) == 1 ? CMD_COSINE : CMD_SINE, a);
    end
    arg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
